[rtl/core/qau_pkg.sv]
// Shared types and constants for the quaternion arithmetic unit.
package qau_pkg;

  localparam int QBITS      = 32;  // component width
  localparam int NORM_W     = 65;  // squared norm, exact
  localparam int SUM_W      = 66;  // sum of four 64-bit products
  localparam int DIV_STAGES = 32;  // one quotient bit per stage

  typedef logic signed [QBITS-1:0] comp_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_INV = 2'd3
  } op_t;

  // Product term signs, bit t set when term t is subtracted (rows w, i, j, k).
  localparam logic [3:0] NEG_TBL [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // State that rides alongside the divider lanes.
  typedef struct packed {
    logic                  inv;
    logic                  zdiv;
    logic                  sat;
    logic [3:0]            neg;
    logic [3:0]            ovf;
    logic [3:0][QBITS-1:0] r;
  } byp_t;

endpackage

[rtl/core/qau_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
module qau_div_lane #(
  parameter int NUM_W = 66
) (
  input  logic                           clk,
  input  logic [qau_pkg::DIV_STAGES-1:0] step_en,
  input  logic [NUM_W-1:0]               num_in,
  input  logic [qau_pkg::NORM_W-1:0]     den_in,
  output logic [qau_pkg::QBITS-1:0]      quo_out
);
  import qau_pkg::*;

  logic [NORM_W-1:0] rem_r [DIV_STAGES];
  logic [QBITS-1:0]  lo_r  [DIV_STAGES];
  logic [QBITS-1:0]  q_r   [DIV_STAGES];
  logic [NORM_W-1:0] den_r [DIV_STAGES];

  logic [NORM_W-1:0] rem_i [DIV_STAGES];
  logic [QBITS-1:0]  lo_i  [DIV_STAGES];
  logic [QBITS-1:0]  q_i   [DIV_STAGES];
  logic [NORM_W-1:0] den_i [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    logic [NORM_W:0]   trial;
    logic              ge;
    logic [NORM_W-1:0] rem_nxt;

    if (s == 0) begin : g_first
      // numerator high part is already below the divisor (no overflow case)
      assign rem_i[s] = NORM_W'(num_in >> QBITS);
      assign lo_i[s]  = num_in[QBITS-1:0];
      assign q_i[s]   = '0;
      assign den_i[s] = den_in;
    end else begin : g_next
      assign rem_i[s] = rem_r[s-1];
      assign lo_i[s]  = lo_r[s-1];
      assign q_i[s]   = q_r[s-1];
      assign den_i[s] = den_r[s-1];
    end

    assign trial   = {rem_i[s], lo_i[s][QBITS-1]};
    assign ge      = trial >= {1'b0, den_i[s]};
    assign rem_nxt = ge ? NORM_W'(trial - {1'b0, den_i[s]}) : trial[NORM_W-1:0];

    always_ff @(posedge clk) begin
      if (step_en[s]) begin
        rem_r[s] <= rem_nxt;
        lo_r[s]  <= {lo_i[s][QBITS-2:0], 1'b0};
        q_r[s]   <= {q_i[s][QBITS-2:0], ge};
        den_r[s] <= den_i[s];
      end
    end
  end

  assign quo_out = q_r[DIV_STAGES-1];

endmodule

[rtl/core/quaternion_arithmetic_unit_core.sv]
// Quaternion arithmetic unit: add, subtract, Hamilton product, inverse (fixed point).
// Pipeline: input reg, multiply, sum, round/numerator, 32 divider stages and output reg,
//   which every operation passes through.
// Throughput: one beat per cycle unless the output stalls; each stage holds its own valid bit, so a stalled
//   output only backs up the stages behind it and bubbles are squeezed out.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
module quaternion_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_op,
  input  qau_pkg::comp_t in_x_w,
  input  qau_pkg::comp_t in_x_i,
  input  qau_pkg::comp_t in_x_j,
  input  qau_pkg::comp_t in_x_k,
  input  qau_pkg::comp_t in_y_w,
  input  qau_pkg::comp_t in_y_i,
  input  qau_pkg::comp_t in_y_j,
  input  qau_pkg::comp_t in_y_k,
  output logic           out_valid,
  input  logic           out_ready,
  output qau_pkg::comp_t out_r_w,
  output qau_pkg::comp_t out_r_i,
  output qau_pkg::comp_t out_r_j,
  output qau_pkg::comp_t out_r_k,
  output logic           out_zero_divide,
  output logic           out_saturated
);
  import qau_pkg::*;

  // numerator |x| << 2F plus half the norm, plus one headroom bit
  localparam int NUM_W = ((2*FRAC_BITS + QBITS > NORM_W) ? 2*FRAC_BITS + QBITS : NORM_W) + 1;
  localparam int CMP_W = NORM_W + QBITS;
  localparam int ST_D  = 3;
  localparam int ST_E  = ST_D + DIV_STAGES + 1;
  localparam int NST   = ST_E + 1;

  // ---------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor moves.
  // ---------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] vin;
  logic [NST-1:0] rdy;
  logic [NST-1:0] en;

  assign vin = {v_r[NST-2:0], in_valid};

  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = out_ready | ~(&v_r[NST-1:i]);
  end

  assign en        = rdy & vin;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= vin[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage A: input capture
  // ---------------------------------------------------------------
  op_t   a_op_r;
  comp_t a_x_r [4];
  comp_t a_y_r [4];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_op_r   <= op_t'(in_op);
      a_x_r[0] <= in_x_w;
      a_x_r[1] <= in_x_i;
      a_x_r[2] <= in_x_j;
      a_x_r[3] <= in_x_k;
      a_y_r[0] <= in_y_w;
      a_y_r[1] <= in_y_i;
      a_y_r[2] <= in_y_j;
      a_y_r[3] <= in_y_k;
    end
  end

  // ---------------------------------------------------------------
  // Stage B: 16 products, add/sub with saturation, magnitudes of X.
  // Row w squares X for the inverse so the norm shares the multipliers.
  // Term t of row r pairs x[t] with y[t ^ r].
  // ---------------------------------------------------------------
  logic signed [63:0] b_p_nxt [4][4];
  comp_t              b_as_nxt [4];
  logic               b_as_sat_nxt;
  logic [QBITS-1:0]   b_mag_nxt [4];
  logic [3:0]         b_neg_nxt;

  always_comb begin
    comp_t              bsel;
    logic signed [32:0] s33;
    b_as_sat_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      for (int t = 0; t < 4; t++) begin
        bsel = (r == 0 && a_op_r == OP_INV) ? a_x_r[t] : a_y_r[2'(t ^ r)];
        b_p_nxt[r][t] = a_x_r[t] * bsel;
      end
    end
    for (int t = 0; t < 4; t++) begin
      if (a_op_r == OP_SUB) begin
        s33 = {a_x_r[t][QBITS-1], a_x_r[t]} - {a_y_r[t][QBITS-1], a_y_r[t]};
      end else begin
        s33 = {a_x_r[t][QBITS-1], a_x_r[t]} + {a_y_r[t][QBITS-1], a_y_r[t]};
      end
      if (s33[32] != s33[31]) begin
        b_as_sat_nxt = 1'b1;
        b_as_nxt[t]  = s33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        b_as_nxt[t]  = s33[31:0];
      end
      b_mag_nxt[t] = a_x_r[t][QBITS-1] ? (32'd0 - a_x_r[t]) : a_x_r[t];
      b_neg_nxt[t] = a_x_r[t][QBITS-1] ^ (t != 0);
    end
  end

  op_t                b_op_r;
  logic signed [63:0] b_p_r [4][4];
  comp_t              b_as_r [4];
  logic               b_as_sat_r;
  logic [QBITS-1:0]   b_mag_r [4];
  logic [3:0]         b_neg_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_op_r     <= a_op_r;
      b_p_r      <= b_p_nxt;
      b_as_r     <= b_as_nxt;
      b_as_sat_r <= b_as_sat_nxt;
      b_mag_r    <= b_mag_nxt;
      b_neg_r    <= b_neg_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage C: signed product sums with round bias, squared norm
  // ---------------------------------------------------------------
  logic signed [SUM_W-1:0] c_s_nxt [4];
  logic [NORM_W-1:0]       c_n_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] pe;
    for (int r = 0; r < 4; r++) begin
      acc = SUM_W'(1) << (FRAC_BITS - 1);
      for (int t = 0; t < 4; t++) begin
        pe  = {{(SUM_W-64){b_p_r[r][t][63]}}, b_p_r[r][t]};
        acc = NEG_TBL[r][t] ? acc - pe : acc + pe;
      end
      c_s_nxt[r] = acc;
    end
    c_n_nxt = {1'b0, b_p_r[0][0]} + {1'b0, b_p_r[0][1]}
            + {1'b0, b_p_r[0][2]} + {1'b0, b_p_r[0][3]};
  end

  op_t                     c_op_r;
  logic signed [SUM_W-1:0] c_s_r [4];
  logic [NORM_W-1:0]       c_n_r;
  comp_t                   c_as_r [4];
  logic                    c_as_sat_r;
  logic [QBITS-1:0]        c_mag_r [4];
  logic [3:0]              c_neg_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_op_r     <= b_op_r;
      c_s_r      <= c_s_nxt;
      c_n_r      <= c_n_nxt;
      c_as_r     <= b_as_r;
      c_as_sat_r <= b_as_sat_r;
      c_mag_r    <= b_mag_r;
      c_neg_r    <= b_neg_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage D: product rescale and clip, inverse numerators, quotient overflow
  // ---------------------------------------------------------------
  byp_t             d_byp_nxt;
  logic [NUM_W-1:0] d_num_nxt [4];

  always_comb begin
    logic signed [SUM_W-1:0] rsh;
    logic                    hi_clip;
    logic                    lo_clip;
    d_byp_nxt      = '0;
    d_byp_nxt.inv  = (c_op_r == OP_INV);
    d_byp_nxt.zdiv = (c_op_r == OP_INV) && (c_n_r == '0);
    d_byp_nxt.neg  = c_neg_r;
    d_byp_nxt.sat  = (c_op_r == OP_ADD || c_op_r == OP_SUB) ? c_as_sat_r : 1'b0;
    for (int r = 0; r < 4; r++) begin
      rsh     = c_s_r[r] >>> FRAC_BITS;
      hi_clip = !rsh[SUM_W-1] && (|rsh[SUM_W-2:QBITS-1]);
      lo_clip = rsh[SUM_W-1] && !(&rsh[SUM_W-2:QBITS-1]);
      if (c_op_r == OP_ADD || c_op_r == OP_SUB) begin
        d_byp_nxt.r[r] = c_as_r[r];
      end else if (hi_clip) begin
        d_byp_nxt.r[r] = 32'h7FFF_FFFF;
        d_byp_nxt.sat  = 1'b1;
      end else if (lo_clip) begin
        d_byp_nxt.r[r] = 32'h8000_0000;
        d_byp_nxt.sat  = 1'b1;
      end else begin
        d_byp_nxt.r[r] = rsh[QBITS-1:0];
      end
      d_num_nxt[r]     = (NUM_W'(c_mag_r[r]) << (2*FRAC_BITS)) + NUM_W'(c_n_r >> 1);
      // quotient of 2^32 or more clips regardless of sign
      d_byp_nxt.ovf[r] = CMP_W'(d_num_nxt[r]) >= {c_n_r, {QBITS{1'b0}}};
    end
    d_byp_nxt.sat = d_byp_nxt.inv ? 1'b0 : d_byp_nxt.sat;
  end

  byp_t              byp_r [DIV_STAGES+1];
  logic [NUM_W-1:0]  d_num_r [4];
  logic [NORM_W-1:0] d_n_r;

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      d_num_r  <= d_num_nxt;
      d_n_r    <= c_n_r;
    end
  end

  // ---------------------------------------------------------------
  // Divider lanes, one per component, with the side state delayed alongside
  // ---------------------------------------------------------------
  logic [QBITS-1:0] lane_q [4];

  for (genvar c = 0; c < 4; c++) begin : g_lane
    qau_div_lane #(
      .NUM_W(NUM_W)
    ) u_lane (
      .clk     (clk),
      .step_en (en[ST_D+1 +: DIV_STAGES]),
      .num_in  (d_num_r[c]),
      .den_in  (d_n_r),
      .quo_out (lane_q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      byp_r[0] <= d_byp_nxt;
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[ST_D+1+s]) begin
        byp_r[s+1] <= byp_r[s];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage E: inverse sign and clip, result select, output register
  // ---------------------------------------------------------------
  byp_t  e_byp;
  comp_t e_r_nxt [4];
  logic  e_sat_nxt;

  assign e_byp = byp_r[DIV_STAGES];

  always_comb begin
    logic [QBITS-1:0] lim;
    logic [QBITS-1:0] mag;
    logic             clip;
    e_sat_nxt = e_byp.sat;
    for (int c = 0; c < 4; c++) begin
      lim  = e_byp.neg[c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      clip = e_byp.ovf[c] || (lane_q[c] > lim);
      mag  = clip ? lim : lane_q[c];
      if (!e_byp.inv) begin
        e_r_nxt[c] = e_byp.r[c];
      end else if (e_byp.zdiv) begin
        e_r_nxt[c] = '0;
      end else begin
        e_r_nxt[c] = e_byp.neg[c] ? (32'd0 - mag) : mag;
        e_sat_nxt  = e_sat_nxt | clip;
      end
    end
  end

  comp_t e_r_r [4];
  logic  e_zd_r;
  logic  e_sat_r;

  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      e_r_r   <= e_r_nxt;
      e_zd_r  <= e_byp.zdiv;
      e_sat_r <= e_sat_nxt;
    end
  end

  assign out_r_w         = e_r_r[0];
  assign out_r_i         = e_r_r[1];
  assign out_r_j         = e_r_r[2];
  assign out_r_k         = e_r_r[3];
  assign out_zero_divide = e_zd_r;
  assign out_saturated   = e_sat_r;

`ifndef SYNTHESIS
  // an empty output stage always frees the whole chain back to the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  // inverse of zero yields a zero quaternion and no clip
  a_zero_divide_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_divide |->
      out_r_w == '0 && out_r_i == '0 && out_r_j == '0 && out_r_k == '0 && !out_saturated)
    else $error("zero divide with nonzero result");

  // nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule
